/* rtl/sfa_pkg.sv */
// ----------------------------------------------------------------------------
// sfa_pkg: shared types and constants of the frame receiver
// Frame geometry, scaling constants, microcode word layout and status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sfa_pkg;

    // frame geometry
    localparam int FRAME_BYTES  = 24;
    localparam int NUM_CHANNELS = 10;
    localparam int STORE_DEPTH  = 1 + (11 * NUM_CHANNELS + 7) / 8;
    localparam int DATA_W       = (STORE_DEPTH - 1) * 8;
    localparam int CH_SLOTS     = (NUM_CHANNELS > 5) ? NUM_CHANNELS : 5;
    localparam int K_W          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int POS_W        = $clog2(FRAME_BYTES + 1);

    // field widths
    localparam int RAW_W = 11;
    localparam int CH_W  = 12;
    localparam int ANG_W = 7;
    localparam int IDX_W = 4;
    localparam int NUM_W = 21;
    localparam int Q_W   = 11;
    localparam int REC_W = 26;
    localparam int REC_SHIFT = 32;

    // scaling constants
    localparam logic [CH_W-1:0] RAW_LO    = 12'd240;
    localparam logic [CH_W-1:0] CH_LO     = 12'd1000;
    localparam logic [9:0]      CH_SPAN   = 10'd1000;
    localparam logic [9:0]      ANG_SPAN  = 10'd9;
    localparam logic [10:0]     DIV_CH    = 11'd1567;
    localparam logic [10:0]     DIV_ANG   = 11'd100;
    localparam logic [REC_W-1:0] RECIP_CH  = REC_W'((64'd1 << REC_SHIFT) / 64'd1567);
    localparam logic [REC_W-1:0] RECIP_ANG = REC_W'((64'd1 << REC_SHIFT) / 64'd100);
    localparam logic signed [12:0] OFS_CH  = 13'sd1000;
    localparam logic signed [12:0] OFS_ANG = -13'sd45;

    // stick thresholds and defaults
    localparam logic [CH_W-1:0] ARM_HIGH   = 12'd1950;
    localparam logic [CH_W-1:0] CENTER_LO  = 12'd1485;
    localparam logic [CH_W-1:0] CENTER_HI  = 12'd1515;
    localparam logic [CH_W-1:0] STICK_LOW  = 12'd1015;
    localparam logic [CH_W-1:0] CH_CENTER  = 12'd1500;
    localparam logic [CH_W-1:0] CH_IDLE    = 12'd1000;

    // configuration register indexes
    localparam logic REG_LOST_LIMIT   = 1'b0;
    localparam logic REG_FRAME_HEADER = 1'b1;

    // item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // microcode
    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_NOP  = 4'd0,
        OP_WAIT = 4'd1,
        OP_PREP = 4'd2,
        OP_MULR = 4'd3,
        OP_MULQ = 4'd4,
        OP_FIX  = 4'd5,
        OP_DONE = 4'd6,
        OP_TICK = 4'd7,
        OP_EMIT = 4'd8
    } op_t;

    typedef enum logic {
        MODE_CHAN  = 1'b0,
        MODE_ANGLE = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        JC_NEXT     = 3'd0,
        JC_GOTO     = 3'd1,
        JC_DISPATCH = 3'd2,
        JC_LOOP_K   = 3'd3,
        JC_LOOP_A   = 3'd4,
        JC_EMIT     = 3'd5
    } jcond_t;

    typedef logic [PC_W-1:0] pc_t;

    typedef struct packed {
        op_t    op;
        mode_t  mode;
        jcond_t cond;
        pc_t    target;
    } uctrl_t;

    typedef struct packed {
        logic in_fire;
        logic in_tick;
        logic close_ok;
        logic k_last;
        logic a_last;
        logic out_fire;
    } dp_status_t;

    // program addresses
    localparam pc_t PC_WAIT     = 4'd0;
    localparam pc_t PC_CH_PREP  = 4'd1;
    localparam pc_t PC_CH_MULR  = 4'd2;
    localparam pc_t PC_CH_MULQ  = 4'd3;
    localparam pc_t PC_CH_FIX   = 4'd4;
    localparam pc_t PC_AN_PREP  = 4'd5;
    localparam pc_t PC_AN_MULR  = 4'd6;
    localparam pc_t PC_AN_MULQ  = 4'd7;
    localparam pc_t PC_AN_FIX   = 4'd8;
    localparam pc_t PC_DONE     = 4'd9;
    localparam pc_t PC_TICK     = 4'd10;
    localparam pc_t PC_EMIT     = 4'd11;

    function automatic logic [CH_W-1:0] ch_default(input int idx);
        if (idx == 0 || idx == 1 || idx == 3) begin
            return CH_CENTER;
        end
        return CH_IDLE;
    endfunction

endpackage

`default_nettype wire

/* rtl/sfa_ucode_rom.sv */
// ----------------------------------------------------------------------------
// sfa_ucode_rom: control program of the frame receiver
// One control word per step: datapath operation, operand mode and next-step rule.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_ucode_rom
    import sfa_pkg::*;
(
    input  wire pc_t    pc,
    output uctrl_t      word
);

    always_comb begin
        word = '{op: OP_NOP, mode: MODE_CHAN, cond: JC_GOTO, target: PC_WAIT};
        case (pc)
            PC_WAIT:    word = '{op: OP_WAIT, mode: MODE_CHAN,  cond: JC_DISPATCH, target: PC_TICK};
            // channel decode loop
            PC_CH_PREP: word = '{op: OP_PREP, mode: MODE_CHAN,  cond: JC_NEXT,   target: PC_WAIT};
            PC_CH_MULR: word = '{op: OP_MULR, mode: MODE_CHAN,  cond: JC_NEXT,   target: PC_WAIT};
            PC_CH_MULQ: word = '{op: OP_MULQ, mode: MODE_CHAN,  cond: JC_NEXT,   target: PC_WAIT};
            PC_CH_FIX:  word = '{op: OP_FIX,  mode: MODE_CHAN,  cond: JC_LOOP_K, target: PC_CH_PREP};
            // roll, pitch, yaw angle loop
            PC_AN_PREP: word = '{op: OP_PREP, mode: MODE_ANGLE, cond: JC_NEXT,   target: PC_WAIT};
            PC_AN_MULR: word = '{op: OP_MULR, mode: MODE_ANGLE, cond: JC_NEXT,   target: PC_WAIT};
            PC_AN_MULQ: word = '{op: OP_MULQ, mode: MODE_ANGLE, cond: JC_NEXT,   target: PC_WAIT};
            PC_AN_FIX:  word = '{op: OP_FIX,  mode: MODE_ANGLE, cond: JC_LOOP_A, target: PC_AN_PREP};
            PC_DONE:    word = '{op: OP_DONE, mode: MODE_CHAN,  cond: JC_GOTO,   target: PC_WAIT};
            // failsafe tick and result words
            PC_TICK:    word = '{op: OP_TICK, mode: MODE_CHAN,  cond: JC_NEXT,   target: PC_WAIT};
            PC_EMIT:    word = '{op: OP_EMIT, mode: MODE_CHAN,  cond: JC_EMIT,   target: PC_WAIT};
            default:    word = '{op: OP_NOP,  mode: MODE_CHAN,  cond: JC_GOTO,   target: PC_WAIT};
        endcase
    end

endmodule

`default_nettype wire

/* rtl/sfa_sequencer.sv */
// ----------------------------------------------------------------------------
// sfa_sequencer: step counter of the frame receiver
// Holds the program counter, reads the control table and resolves jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_sequencer
    import sfa_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  dp_status_t  status,
    output uctrl_t      ctrl
);

    pc_t pc_reg;
    pc_t pc_next;
    pc_t pc_inc;

    sfa_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (ctrl)
    );

    assign pc_inc = pc_reg + pc_t'(1);

    always_comb begin
        pc_next = pc_reg;
        case (ctrl.cond)
            JC_NEXT: begin
                pc_next = pc_inc;
            end
            JC_GOTO: begin
                pc_next = ctrl.target;
            end
            JC_DISPATCH: begin
                // tick goes to the failsafe step, a good closing byte to decode
                if (status.in_fire) begin
                    if (status.in_tick) begin
                        pc_next = ctrl.target;
                    end else if (status.close_ok) begin
                        pc_next = pc_inc;
                    end
                end
            end
            JC_LOOP_K: begin
                pc_next = status.k_last ? pc_inc : ctrl.target;
            end
            JC_LOOP_A: begin
                pc_next = status.a_last ? pc_inc : ctrl.target;
            end
            JC_EMIT: begin
                if (status.out_fire && status.k_last) begin
                    pc_next = ctrl.target;
                end
            end
            default: begin
                pc_next = PC_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/sfa_datapath.sv */
// ----------------------------------------------------------------------------
// sfa_datapath: stores and arithmetic of the frame receiver
// Frame window, channel and angle stores, shared scaling unit, failsafe state.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_datapath
    import sfa_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  uctrl_t                  ctrl,
    input  wire [7:0]               lost_limit,
    input  wire [7:0]               frame_header,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire                     s_func,
    input  wire [7:0]               s_rx_byte,
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [IDX_W-1:0]        m_channel_index,
    output logic [CH_W-1:0]         m_channel_value,
    output logic signed [ANG_W-1:0] m_angle_value,
    output logic                    m_armed,
    output logic                    m_motors_enabled,
    output logic                    m_failsafe_trip,
    output logic                    m_pid_reset,
    output logic                    m_last,
    output dp_status_t              status
);

    // window
    logic [POS_W-1:0]  pos_reg;
    logic [7:0]        hdr_byte_reg;
    logic [DATA_W-1:0] frame_data_reg;

    // stores
    logic [CH_W-1:0]  ch_reg  [CH_SLOTS];
    logic [ANG_W-1:0] ang_reg [3];

    // link state
    logic       frame_good_reg;
    logic [7:0] lost_reg;
    logic       link_reg;
    logic       armed_reg;
    logic       motor_reg;
    logic       alert_reg;
    logic       pid_reg;

    // loop counters
    logic [K_W-1:0] k_reg;
    logic [1:0]     a_reg;

    // scaling unit
    logic [NUM_W-1:0] num_reg;
    logic             neg_reg;
    logic [Q_W-1:0]   q_reg;
    logic [CH_W-1:0]  rem_reg;

    logic in_fire, out_fire, is_byte, byte_open, k_last, a_last;

    assign s_ready  = (ctrl.op == OP_WAIT);
    assign m_valid  = (ctrl.op == OP_EMIT);
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign is_byte  = (s_func == FUNC_BYTE);
    assign byte_open = (pos_reg < POS_W'(FRAME_BYTES));
    assign k_last   = (k_reg == K_W'(NUM_CHANNELS - 1));
    assign a_last   = (a_reg == 2'd2);

    assign status.in_fire  = in_fire;
    assign status.in_tick  = (s_func == FUNC_TICK);
    assign status.close_ok = is_byte && (pos_reg == POS_W'(FRAME_BYTES - 1))
                             && (hdr_byte_reg == frame_header);
    assign status.k_last   = k_last;
    assign status.a_last   = a_last;
    assign status.out_fire = out_fire;

    // ---------------- scaling unit operand selection ----------------
    logic [CH_W-1:0]  ang_src, src_val, bias;
    logic signed [12:0] diff;
    logic [12:0]      mag13;
    logic [21:0]      num_full;
    logic [REC_W-1:0] recip;
    logic [10:0]      divisor;
    logic [46:0]      prod;
    logic [21:0]      qd, rem_full;
    logic [CH_W-1:0]  qf;
    logic signed [12:0] sres, res;

    always_comb begin
        case (a_reg)
            2'd0:    ang_src = ch_reg[0];
            2'd1:    ang_src = ch_reg[1];
            default: ang_src = ch_reg[3];
        endcase
    end

    assign src_val  = (ctrl.mode == MODE_CHAN) ? {1'b0, frame_data_reg[RAW_W-1:0]} : ang_src;
    assign bias     = (ctrl.mode == MODE_CHAN) ? RAW_LO : CH_LO;
    assign diff     = $signed({1'b0, src_val}) - $signed({1'b0, bias});
    assign mag13    = diff[12] ? 13'(-diff) : 13'(diff);
    assign num_full = mag13[CH_W-1:0] * ((ctrl.mode == MODE_CHAN) ? CH_SPAN : ANG_SPAN);
    assign recip    = (ctrl.mode == MODE_CHAN) ? RECIP_CH : RECIP_ANG;
    assign divisor  = (ctrl.mode == MODE_CHAN) ? DIV_CH : DIV_ANG;
    assign prod     = num_reg * recip;
    assign qd       = q_reg * divisor;
    assign rem_full = {1'b0, num_reg} - qd;
    // the estimate is at most one low; one compare fixes it
    assign qf       = {1'b0, q_reg} + ((rem_reg >= {1'b0, divisor}) ? 12'd1 : 12'd0);
    assign sres     = neg_reg ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
    assign res      = sres + ((ctrl.mode == MODE_CHAN) ? OFS_CH : OFS_ANG);

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_PREP: begin
                num_reg <= num_full[NUM_W-1:0];
                neg_reg <= diff[12];
            end
            OP_MULR: begin
                q_reg <= prod[REC_SHIFT +: Q_W];
            end
            OP_MULQ: begin
                rem_reg <= rem_full[CH_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // ---------------- frame window ----------------
    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_WAIT && in_fire && is_byte && byte_open) begin
            if (pos_reg == '0) begin
                hdr_byte_reg <= s_rx_byte;
            end
            for (int i = 1; i < STORE_DEPTH; i++) begin
                if (pos_reg == POS_W'(i)) begin
                    frame_data_reg[(i - 1) * 8 +: 8] <= s_rx_byte;
                end
            end
        end else if (ctrl.op == OP_PREP && ctrl.mode == MODE_CHAN) begin
            // advance to the next packed channel
            frame_data_reg <= frame_data_reg >> RAW_W;
        end
    end

    // ---------------- failsafe and stick checks ----------------
    logic [7:0] lost_next;
    logic       trip, link_next, motor_next, arm_cond, arm_now, armed_next;

    function automatic logic centered(input logic [CH_W-1:0] v);
        return (v > CENTER_LO) && (v < CENTER_HI);
    endfunction

    assign lost_next  = frame_good_reg ? 8'd0 : lost_reg + 8'd1;
    assign trip       = (lost_next == lost_limit);
    assign link_next  = (frame_good_reg || link_reg) && !trip;
    assign motor_next = link_next || (!trip && motor_reg);
    assign arm_cond   = (ch_reg[4] > ARM_HIGH) && (ch_reg[2] < STICK_LOW)
                        && centered(ch_reg[0]) && centered(ch_reg[1]) && centered(ch_reg[3]);
    assign arm_now    = !trip && !armed_reg && arm_cond;
    assign armed_next = arm_now || (!trip && armed_reg && !(ch_reg[4] < STICK_LOW));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            frame_good_reg <= 1'b0;
            lost_reg       <= '0;
            link_reg       <= 1'b0;
            armed_reg      <= 1'b0;
            motor_reg      <= 1'b0;
            alert_reg      <= 1'b0;
            pid_reg        <= 1'b0;
            k_reg          <= '0;
            a_reg          <= '0;
            for (int i = 0; i < CH_SLOTS; i++) begin
                ch_reg[i] <= ch_default(i);
            end
            for (int j = 0; j < 3; j++) begin
                ang_reg[j] <= '0;
            end
        end else begin
            case (ctrl.op)
                OP_WAIT: begin
                    if (in_fire && is_byte && byte_open) begin
                        pos_reg <= pos_reg + POS_W'(1);
                        if (pos_reg == POS_W'(FRAME_BYTES - 1) && hdr_byte_reg != frame_header) begin
                            frame_good_reg <= 1'b0;
                        end
                    end
                end
                OP_FIX: begin
                    if (ctrl.mode == MODE_CHAN) begin
                        for (int i = 0; i < NUM_CHANNELS; i++) begin
                            if (k_reg == K_W'(i)) begin
                                ch_reg[i] <= res[CH_W-1:0];
                            end
                        end
                        k_reg <= k_last ? '0 : k_reg + K_W'(1);
                    end else begin
                        ang_reg[a_reg] <= res[ANG_W-1:0];
                        a_reg <= a_last ? 2'd0 : a_reg + 2'd1;
                    end
                end
                OP_DONE: begin
                    frame_good_reg <= 1'b1;
                end
                OP_TICK: begin
                    lost_reg  <= lost_next;
                    link_reg  <= link_next;
                    motor_reg <= motor_next;
                    armed_reg <= armed_next;
                    alert_reg <= trip;
                    pid_reg   <= trip || arm_now;
                    if (trip) begin
                        for (int i = 0; i < CH_SLOTS; i++) begin
                            ch_reg[i] <= ch_default(i);
                        end
                    end
                    // reopen the window
                    frame_good_reg <= 1'b0;
                    pos_reg        <= '0;
                end
                OP_EMIT: begin
                    if (out_fire) begin
                        k_reg <= k_last ? '0 : k_reg + K_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- result word ----------------
    always_comb begin
        m_channel_value = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (k_reg == K_W'(i)) begin
                m_channel_value = ch_reg[i];
            end
        end
    end

    assign m_channel_index = IDX_W'(k_reg);

    always_comb begin
        if (m_channel_index == 4'd0) begin
            m_angle_value = ang_reg[0];
        end else if (m_channel_index == 4'd1) begin
            m_angle_value = ang_reg[1];
        end else if (m_channel_index == 4'd3) begin
            m_angle_value = ang_reg[2];
        end else begin
            m_angle_value = '0;
        end
    end

    assign m_armed          = armed_reg;
    assign m_motors_enabled = motor_reg;
    assign m_failsafe_trip  = alert_reg;
    assign m_pid_reset      = pid_reg;
    assign m_last           = k_last;

endmodule

`default_nettype wire

/* rtl/sbus_receiver_failsafe_arm_unit.sv */
// ----------------------------------------------------------------------------
// sbus_receiver_failsafe_arm_unit: serial frame receiver with failsafe and arming
// Input words are received bytes (s_func 0) or failsafe ticks (s_func 1).
// Each tick returns one result word per channel on the m_ channel, index 0 first,
// with m_last on the final one. Bytes return nothing.
// A byte that does not close the window is taken and s_ready stays high.
// The byte that closes the 24-byte window with a matching header starts the
// decode program: 4 steps per channel through the shared multiply unit, then
// 4 steps for each of the three angles and one to mark the frame, all with
// s_ready low. A tick runs the failsafe and stick checks and then returns one
// result word per cycle while m_ready stays high.
// The control program handles one word at a time: s_ready stays low while
// results are shown, and a stalled m_ready simply holds the current result.
// Reset opens the window, loads default channels (1500 on roll, pitch, yaw,
// 1000 elsewhere), clears the angles, disarms, disables the motors and sets
// the lost-frame limit to 10 and the expected header to 15.
// Configuration writes take effect on the next cycle; the user must make them while idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_receiver_failsafe_arm_unit
    import sfa_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    // configuration
    input  wire                     cfg_wr_en,
    input  wire                     cfg_index,
    input  wire [7:0]               cfg_wdata,
    // input words
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire                     s_func,
    input  wire [7:0]               s_rx_byte,
    // result words
    output logic                    m_valid,
    input  wire                     m_ready,
    output logic [IDX_W-1:0]        m_channel_index,
    output logic [CH_W-1:0]         m_channel_value,
    output logic signed [ANG_W-1:0] m_angle_value,
    output logic                    m_armed,
    output logic                    m_motors_enabled,
    output logic                    m_failsafe_trip,
    output logic                    m_pid_reset,
    output logic                    m_last
);

    logic [7:0] lost_limit_reg;
    logic [7:0] header_reg;
    uctrl_t     ctrl;
    dp_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lost_limit_reg <= 8'd10;
            header_reg     <= 8'd15;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LOST_LIMIT:   lost_limit_reg <= cfg_wdata;
                REG_FRAME_HEADER: header_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    sfa_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    sfa_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .lost_limit        (lost_limit_reg),
        .frame_header      (header_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_channel_index   (m_channel_index),
        .m_channel_value   (m_channel_value),
        .m_angle_value     (m_angle_value),
        .m_armed           (m_armed),
        .m_motors_enabled  (m_motors_enabled),
        .m_failsafe_trip   (m_failsafe_trip),
        .m_pid_reset       (m_pid_reset),
        .m_last            (m_last),
        .status            (status)
    );

endmodule

`default_nettype wire

/* rtl/sfa_checker.sv */
// ----------------------------------------------------------------------------
// sfa_checker: port-level checks of the frame receiver
// Watches the top-level ports and flags broken result sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_checker
    import sfa_pkg::*;
(
    input wire              aclk,
    input wire              aresetn,
    input wire              s_ready,
    input wire              m_valid,
    input wire              m_ready,
    input wire [IDX_W-1:0]  m_channel_index,
    input wire              m_armed,
    input wire              m_motors_enabled,
    input wire              m_failsafe_trip,
    input wire              m_last
);

    // hold the channel index of a result word while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_channel_index))
        else $error("result word changed while stalled");

    // one word in flight: no intake while results are shown
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while results pending");

    // results of a tick come back to back in channel order
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=>
            m_valid && (m_channel_index == $past(m_channel_index) + 4'd1))
        else $error("channel index did not advance");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_channel_index == IDX_W'(NUM_CHANNELS - 1))
        else $error("last flag on wrong channel");

    // a tripped failsafe leaves the craft disarmed with motors off
    a_trip_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_failsafe_trip |-> !m_armed && !m_motors_enabled)
        else $error("failsafe tripped but still armed or enabled");

endmodule

bind sbus_receiver_failsafe_arm_unit sfa_checker u_sfa_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_channel_index  (m_channel_index),
    .m_armed          (m_armed),
    .m_motors_enabled (m_motors_enabled),
    .m_failsafe_trip  (m_failsafe_trip),
    .m_last           (m_last)
);

`default_nettype wire

/* bench/sbus_receiver_failsafe_arm_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_receiver_failsafe_arm_unit_tb: self-checking bench of the frame receiver
// Feeds byte and tick words through a valid/ready driver, predicts the channel
// results of every tick from a behavioral copy of the receiver, and checks
// each result word field by field across several register settings.
// ----------------------------------------------------------------------------
module sbus_receiver_failsafe_arm_unit_tb;
    import sfa_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_WORDS   = 65;

    // scaling end points
    localparam int RAW_MIN = 240;
    localparam int RAW_MAX = 1807;
    localparam int CH_MIN  = 1000;
    localparam int CH_MAX  = 2000;
    localparam int ANG_MIN = -45;
    localparam int ANG_MAX = 45;

    typedef struct {
        logic       func;
        logic [7:0] data;
    } in_word_t;

    typedef struct {
        logic [IDX_W-1:0]        index;
        logic [CH_W-1:0]         value;
        logic signed [ANG_W-1:0] angle;
        logic                    armed;
        logic                    motors;
        logic                    alert;
        logic                    pid;
        logic                    last;
    } chan_result_t;

    typedef enum {STICKS_ARM, STICKS_NEAR, STICKS_DISARM, STICKS_RANDOM} stick_style_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic                    cfg_index = REG_LOST_LIMIT;
    logic [7:0]              cfg_wdata = 8'd0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_func = FUNC_BYTE;
    logic [7:0]              s_rx_byte = 8'd0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [IDX_W-1:0]        m_channel_index;
    logic [CH_W-1:0]         m_channel_value;
    logic signed [ANG_W-1:0] m_angle_value;
    logic                    m_armed;
    logic                    m_motors_enabled;
    logic                    m_failsafe_trip;
    logic                    m_pid_reset;
    logic                    m_last;

    in_word_t     pending_words[$];
    chan_result_t expected_results[$];
    in_word_t     cur_word;
    chan_result_t want;
    int           err_count = 0;
    int           words_queued = 0;
    int           send_idle_pct = 30;
    int           recv_idle_pct = 88;
    int           cycles;

    // receiver copy: registers and state
    logic [7:0]              lim_reg = 8'd10;
    logic [7:0]              hdr_reg = 8'd15;
    int                      win_pos = 0;
    logic [7:0]              frame_bytes [STORE_DEPTH];
    logic [CH_W-1:0]         chan_val [CH_SLOTS];
    logic signed [ANG_W-1:0] ang_val [3] = '{default: '0};
    logic                    frame_ok = 1'b0;
    logic [7:0]              lost_cnt = 8'd0;
    logic                    link_up = 1'b0;
    logic                    is_armed = 1'b0;
    logic                    motors_on = 1'b0;

    logic [RAW_W-1:0]        raw_set [NUM_CHANNELS];

    sbus_receiver_failsafe_arm_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_channel_index  (m_channel_index),
        .m_channel_value  (m_channel_value),
        .m_angle_value    (m_angle_value),
        .m_armed          (m_armed),
        .m_motors_enabled (m_motors_enabled),
        .m_failsafe_trip  (m_failsafe_trip),
        .m_pid_reset      (m_pid_reset),
        .m_last           (m_last)
    );

    always #2 aclk = ~aclk;

    // truncating integer map, as the decoder does it
    function automatic int map_range(int x, int in_lo, int in_hi, int out_lo, int out_hi);
        return (x - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
    endfunction

    function automatic void load_default_channels();
        for (int i = 0; i < CH_SLOTS; i++) begin
            chan_val[i] = (i == 0 || i == 1 || i == 3) ? CH_CENTER : CH_IDLE;
        end
    endfunction

    // advance the receiver copy by one word and queue the channel results of a tick
    function automatic void predict_results(logic func, logic [7:0] data);
        chan_result_t      r;
        logic [DATA_W-1:0] payload;
        logic              alert;
        logic              pid;
        alert = 1'b0;
        pid = 1'b0;
        if (func == FUNC_BYTE) begin
            if (win_pos < FRAME_BYTES) begin
                if (win_pos < STORE_DEPTH) begin
                    frame_bytes[win_pos] = data;
                end
                win_pos++;
                if (win_pos == FRAME_BYTES) begin
                    if (frame_bytes[0] != hdr_reg) begin
                        frame_ok = 1'b0;
                    end else begin
                        for (int j = 1; j < STORE_DEPTH; j++) begin
                            payload[8*(j-1) +: 8] = frame_bytes[j];
                        end
                        for (int k = 0; k < NUM_CHANNELS; k++) begin
                            chan_val[k] = CH_W'(map_range(int'(payload[RAW_W*k +: RAW_W]),
                                                          RAW_MIN, RAW_MAX, CH_MIN, CH_MAX));
                        end
                        ang_val[0] = ANG_W'(map_range(int'(chan_val[0]), CH_MIN, CH_MAX,
                                                      ANG_MIN, ANG_MAX));
                        ang_val[1] = ANG_W'(map_range(int'(chan_val[1]), CH_MIN, CH_MAX,
                                                      ANG_MIN, ANG_MAX));
                        ang_val[2] = ANG_W'(map_range(int'(chan_val[3]), CH_MIN, CH_MAX,
                                                      ANG_MIN, ANG_MAX));
                        frame_ok = 1'b1;
                    end
                end
            end
            return;
        end

        if (!frame_ok) begin
            lost_cnt = lost_cnt + 8'd1;
        end else begin
            lost_cnt = 8'd0;
            link_up = 1'b1;
        end
        if (lost_cnt == lim_reg) begin
            load_default_channels();
            pid = 1'b1;
            is_armed = 1'b0;
            alert = 1'b1;
            link_up = 1'b0;
            motors_on = 1'b0;
        end
        if (link_up) begin
            motors_on = 1'b1;
        end
        if (!is_armed && chan_val[4] > ARM_HIGH && chan_val[2] < STICK_LOW
                && chan_val[0] > CENTER_LO && chan_val[0] < CENTER_HI
                && chan_val[1] > CENTER_LO && chan_val[1] < CENTER_HI
                && chan_val[3] > CENTER_LO && chan_val[3] < CENTER_HI) begin
            is_armed = 1'b1;
            pid = 1'b1;
        end
        if (is_armed && chan_val[4] < STICK_LOW) begin
            is_armed = 1'b0;
        end
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            r.index  = IDX_W'(k);
            r.value  = chan_val[k];
            r.angle  = (k == 0) ? ang_val[0] : (k == 1) ? ang_val[1] :
                       (k == 3) ? ang_val[2] : '0;
            r.armed  = is_armed;
            r.motors = motors_on;
            r.alert  = alert;
            r.pid    = pid;
            r.last   = (k == NUM_CHANNELS - 1);
            expected_results.push_back(r);
        end
        frame_ok = 1'b0;
        win_pos = 0;
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            err_count++;
        end
    endfunction

    // input driver: hold a word until it is taken, then maybe idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_results(s_func, s_rx_byte);
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    s_valid   <= 1'b1;
                    s_func    <= cur_word.func;
                    s_rx_byte <= cur_word.data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result word for channel %0d", m_channel_index);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("channel_index", want.index, m_channel_index);
                    check_field("channel_value", want.value, m_channel_value);
                    check_field("angle_value", want.angle, m_angle_value);
                    check_field("armed", want.armed, m_armed);
                    check_field("motors_enabled", want.motors, m_motors_enabled);
                    check_field("failsafe_trip", want.alert, m_failsafe_trip);
                    check_field("pid_reset", want.pid, m_pid_reset);
                    check_field("last", want.last, m_last);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic push_word(input logic func, input logic [7:0] data);
        in_word_t w;
        w.func = func;
        w.data = data;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic fill_raws(input stick_style_t style);
        for (int j = 0; j < NUM_CHANNELS; j++) begin
            case ($urandom_range(3))
                0: raw_set[j] = '0;
                1: raw_set[j] = '1;
                default: raw_set[j] = RAW_W'($urandom);
            endcase
        end
        case (style)
            STICKS_ARM: begin
                raw_set[0] = 11'd1024;
                raw_set[1] = 11'd1024;
                raw_set[3] = 11'd1024;
                raw_set[2] = 11'd0;
                raw_set[4] = 11'd2047;
            end
            // straddle the center, low and high stick thresholds
            STICKS_NEAR: begin
                raw_set[0] = RAW_W'($urandom_range(990, 1060));
                raw_set[1] = RAW_W'($urandom_range(990, 1060));
                raw_set[3] = RAW_W'($urandom_range(990, 1060));
                raw_set[2] = RAW_W'($urandom_range(200, 290));
                raw_set[4] = RAW_W'($urandom_range(1700, 2047));
            end
            STICKS_DISARM: begin
                raw_set[4] = RAW_W'($urandom_range(0, 300));
            end
            default: begin
            end
        endcase
    endtask

    // one full window: header, packed channels, then filler bytes
    task automatic push_frame(input logic [7:0] hdr);
        logic [DATA_W-1:0] packed_ch;
        packed_ch = '0;
        for (int j = 0; j < NUM_CHANNELS; j++) begin
            packed_ch[RAW_W*j +: RAW_W] = raw_set[j];
        end
        push_word(FUNC_BYTE, hdr);
        for (int j = 1; j < FRAME_BYTES; j++) begin
            if (j < STORE_DEPTH) begin
                push_word(FUNC_BYTE, packed_ch[8*(j-1) +: 8]);
            end else begin
                push_word(FUNC_BYTE, 8'($urandom));
            end
        end
    endtask

    task automatic gen_phase(input int n_words);
        int first;
        int r;
        int n;
        first = words_queued;
        while (words_queued - first < n_words) begin
            r = $urandom_range(99);
            if (r < 60) begin
                case ($urandom_range(3))
                    0: fill_raws(STICKS_ARM);
                    1: fill_raws(STICKS_NEAR);
                    2: fill_raws(STICKS_DISARM);
                    default: fill_raws(STICKS_RANDOM);
                endcase
                push_frame(hdr_reg);
                // bytes past a full window are dropped by the block
                if ($urandom_range(3) == 0) begin
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) begin
                        push_word(FUNC_BYTE, 8'($urandom));
                    end
                end
                push_word(FUNC_TICK, 8'($urandom));
            end else if (r < 72) begin
                fill_raws(STICKS_ARM);
                push_frame(hdr_reg ^ 8'($urandom_range(1, 255)));
                push_word(FUNC_TICK, 8'($urandom));
            end else if (r < 86) begin
                n = $urandom_range(1, FRAME_BYTES - 1);
                for (int i = 0; i < n; i++) begin
                    push_word(FUNC_BYTE, 8'($urandom));
                end
                push_word(FUNC_TICK, 8'($urandom));
            end else begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    push_word(FUNC_TICK, 8'($urandom));
                end
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_words.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_LOST_LIMIT) begin
            lim_reg = val;
        end else begin
            hdr_reg = val;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // drain, let a pending decode finish, reprogram, then queue random words
    task automatic run_phase(input logic [7:0] limit, input logic [7:0] hdr,
                             input int send_pct, input int recv_pct);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(REG_LOST_LIMIT, limit);
        write_reg(REG_FRAME_HEADER, hdr);
        @(negedge aclk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        gen_phase(PHASE_WORDS);
    endtask

    initial begin
        load_default_channels();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // window open from reset: arm on a good frame, drop a trailing byte
        fill_raws(STICKS_ARM);
        push_frame(hdr_reg);
        push_word(FUNC_BYTE, 8'hFF);
        push_word(FUNC_TICK, 8'h00);

        run_phase(8'd3, 8'h0F, 30, 88);
        run_phase(8'd0, 8'h00, 30, 88);
        run_phase(8'd255, 8'hFF, 88, 30);
        run_phase(8'd1, 8'($urandom), 88, 30);
        run_phase(8'd10, 8'hA5, 0, 0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
